// ===== src/cron_schedule_matcher_macros.svh =====
// Assertion helpers for the cron schedule matcher.
`ifndef CRON_SCHEDULE_MATCHER_MACROS_SVH
`define CRON_SCHEDULE_MATCHER_MACROS_SVH

// Implication checked on every edge outside reset.
`define CSM_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cron matcher check failed");

// Next-cycle implication checked outside reset.
`define CSM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cron matcher check failed");

`endif

// ===== src/csm_pkg.sv =====
`timescale 1ns / 1ps
package csm_pkg;

	localparam logic [1:0] OP_SET  = 2'd0;
	localparam logic [1:0] OP_MASK = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic [2:0] KIND_MINUTE  = 3'd0;
	localparam logic [2:0] KIND_HOUR    = 3'd1;
	localparam logic [2:0] KIND_DAY     = 3'd2;
	localparam logic [2:0] KIND_MONTH   = 3'd3;
	localparam logic [2:0] KIND_WEEKDAY = 3'd4;

	localparam logic [13:0] YEAR_MIN = 14'd1970;
	localparam logic [13:0] YEAR_MAX = 14'd9999;
	localparam logic [2:0]  WD_EPOCH = 3'd4;

	// Width of the rule index on the mask write bus (up to 64 rules).
	localparam int SLOT_W = 6;

	// Current clock as seen by every cell.
	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [2:0]  weekday;
	} time_t;

	// Mask write broadcast to the cells.
	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [2:0]        kind;
		logic [59:0]       bits;
	} mask_wr_t;

	// y / 100 by reciprocal multiply: exact for any 14-bit year.
	function automatic logic is_leap(input logic [13:0] y);
		logic [26:0] prod;
		logic [7:0]  q100;
		logic        d100;
		prod = 27'(y) * 27'd5243;
		q100 = prod[26:19];
		d100 = ({6'd0, q100} * 14'd100) == y;
		return (y[1:0] == 2'b00) && (!d100 || (q100[1:0] == 2'b00));
	endfunction

	function automatic logic [4:0] days_in(input logic [13:0] y, input logic [3:0] m);
		logic [4:0] d;
		case (m) inside
			4'd2:                    d = is_leap(y) ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
			default:                 d = 5'd31;
		endcase
		return d;
	endfunction

	// Weekday shift contributed by a month: sum of previous month lengths mod 7.
	function automatic logic [2:0] month_offset(input logic [3:0] m, input logic leap);
		logic [2:0] o;
		case (m)
			4'd1:  o = 3'd0;
			4'd2:  o = 3'd3;
			4'd3:  o = 3'd3;
			4'd4:  o = 3'd6;
			4'd5:  o = 3'd1;
			4'd6:  o = 3'd4;
			4'd7:  o = 3'd6;
			4'd8:  o = 3'd2;
			4'd9:  o = 3'd5;
			4'd10: o = 3'd0;
			4'd11: o = 3'd3;
			default: o = 3'd5;
		endcase
		if (leap && m > 4'd2)
			o = (o == 3'd6) ? 3'd0 : o + 3'd1;
		return o;
	endfunction

	function automatic logic [2:0] add7(input logic [2:0] a, input logic [2:0] b);
		logic [3:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= 4'd7) ? 3'(s - 4'd7) : s[2:0];
	endfunction

	// v mod 7 for v in 0..31.
	function automatic logic [2:0] mod7(input logic [4:0] v);
		logic [4:0] r;
		if (v >= 5'd28)
			r = v - 5'd28;
		else if (v >= 5'd21)
			r = v - 5'd21;
		else if (v >= 5'd14)
			r = v - 5'd14;
		else if (v >= 5'd7)
			r = v - 5'd7;
		else
			r = v;
		return r[2:0];
	endfunction

endpackage

// ===== src/csm_cell.sv =====
`timescale 1ns / 1ps
// One rule: holds its five masks, reports a hit for the broadcast time.
module csm_cell #(
	parameter int Index = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  csm_pkg::mask_wr_t wr,
	input  csm_pkg::time_t    now,
	output logic              hit
);
	localparam int SW = csm_pkg::SLOT_W;

	logic [59:0] min_q;
	logic [23:0] hour_q;
	logic [30:0] day_q;
	logic [11:0] mon_q;
	logic [6:0]  wd_q;
	logic        sel;

	assign sel = wr.en && (wr.slot == SW'(Index));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= '0;
			hour_q <= '0;
			day_q  <= '0;
			mon_q  <= '0;
			wd_q   <= '0;
		end else if (sel) begin
			unique case (wr.kind)
				csm_pkg::KIND_MINUTE:  min_q  <= wr.bits;
				csm_pkg::KIND_HOUR:    hour_q <= wr.bits[23:0];
				csm_pkg::KIND_DAY:     day_q  <= wr.bits[30:0];
				csm_pkg::KIND_MONTH:   mon_q  <= wr.bits[11:0];
				csm_pkg::KIND_WEEKDAY: wd_q   <= wr.bits[6:0];
				default: ;
			endcase
		end
	end

	assign hit = min_q[now.minute] && hour_q[now.hour] && day_q[5'(now.day - 5'd1)]
		&& mon_q[4'(now.month - 4'd1)] && wd_q[now.weekday];
endmodule

// ===== src/csm_link.sv =====
`timescale 1ns / 1ps
// Scan chain stage: a token passes one stage per cycle; a stage holding a hit
// keeps the token until its transfer completes.
module csm_link (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic tok_in,
	input  logic hit,
	input  logic take,
	output logic tok_q,
	output logic tok_out
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tok_q <= 1'b0;
		else if (start)
			tok_q <= tok_in;
		else if (tok_q && !(hit && !take))
			tok_q <= 1'b0;
		else if (tok_in)
			tok_q <= 1'b1;
	end

	assign tok_out = tok_q && !(hit && !take);
endmodule

// ===== src/cron_schedule_matcher.sv =====
`timescale 1ns / 1ps
// Cron schedule matcher.
// One input channel (valid/stall) takes ops: set clock, write rule mask, minute tick.
// One output channel (valid/stall) gives one transfer per rule matching the
// current time, ascending, with last on the final one of that tick.
// Mask and undefined ops, taken one per cycle unless stalled, give no output.
// A tick walks a token through a chain of RULE_COUNT cells, one cell a cycle
// except while the output is stalled on a match; a match is offered in the
// cycle its cell holds the token, the token visiting the cells in ascending
// order from cell 0.
// The output drives straight from the cell holding the token; when stalled the
// token waits there, so the payload holds.
// Input stall is high while a tick is being scanned.
// After the scan the clock advances one minute (leap-year aware, wrapping past
// 9999 back to 1970-01-01 Thursday).
// Clock set derives the weekday iteratively: one year per cycle from 1970, so a
// set stalls the input until the walk reaches the set year.
// Reset: clock 1970-01-01 00:00 Thursday, all masks clear, idle.
module cron_schedule_matcher #(
	parameter int RULE_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [13:0] set_year,
	input  logic [3:0]  set_month,
	input  logic [4:0]  set_day,
	input  logic [4:0]  set_hour,
	input  logic [5:0]  set_minute,
	input  logic [3:0]  rule_slot,
	input  logic [2:0]  mask_kind,
	input  logic [59:0] mask_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  fired_rule,
	output logic [13:0] at_year,
	output logic [3:0]  at_month,
	output logic [4:0]  at_day,
	output logic [4:0]  at_hour,
	output logic [5:0]  at_minute,
	output logic        last
);
	`include "cron_schedule_matcher_macros.svh"

	localparam int IW = (RULE_COUNT > 1) ? $clog2(RULE_COUNT) : 1;
	localparam int SW = csm_pkg::SLOT_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_WDAY = 3'b100
	} state_t;

	state_t            state_q;
	csm_pkg::time_t    now_q;
	csm_pkg::mask_wr_t wr;
	logic [13:0]       wy_q;   // year walker for weekday derivation
	logic [2:0]        wacc_q;
	logic              accept, start;
	logic [RULE_COUNT-1:0] hit, tok, tok_nx;
	logic [RULE_COUNT:0]   chain;
	logic              out_take;
	logic [IW-1:0]     cur_idx;
	logic              later_hit;
	logic              scan_done;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign start    = accept && (op == csm_pkg::OP_TICK);

	assign wr.en   = accept && (op == csm_pkg::OP_MASK);
	assign wr.slot = SW'(rule_slot);
	assign wr.kind = mask_kind;
	assign wr.bits = mask_bits;

	// Chain of rule cells and token links; a start plants the token at cell 0.
	assign chain[0] = start;
	for (genvar g = 0; g < RULE_COUNT; g++) begin : g_rule
		csm_cell #(.Index(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .wr(wr), .now(now_q), .hit(hit[g])
		);
		csm_link u_link (
			.clk(clk), .arst_n(arst_n), .start(start),
			.tok_in(chain[g]),
			.hit(hit[g]), .take(out_take), .tok_q(tok[g]), .tok_out(tok_nx[g])
		);
		assign chain[g+1] = tok_nx[g];
	end

	// Output comes from the token holder when its rule hits.
	always_comb begin
		cur_idx   = '0;
		out_valid = 1'b0;
		later_hit = 1'b0;
		for (int i = 0; i < RULE_COUNT; i++) begin
			if (tok[i]) begin
				cur_idx   = IW'(i);
				out_valid = hit[i];
			end
		end
		for (int i = 0; i < RULE_COUNT; i++)
			if (IW'(i) > cur_idx && hit[i])
				later_hit = 1'b1;
	end
	assign out_take   = out_valid && !out_stall;
	assign fired_rule = 4'(cur_idx);
	assign at_year    = now_q.year;
	assign at_month   = now_q.month;
	assign at_day     = now_q.day;
	assign at_hour    = now_q.hour;
	assign at_minute  = now_q.minute;
	assign last       = !later_hit;

	assign scan_done = chain[RULE_COUNT];

	// Saturated set values.
	logic [13:0] sy;
	logic [3:0]  sm;
	logic [4:0]  sd, sh, dm;
	logic [5:0]  smi;
	always_comb begin
		sy  = (set_year < csm_pkg::YEAR_MIN) ? csm_pkg::YEAR_MIN :
		      (set_year > csm_pkg::YEAR_MAX) ? csm_pkg::YEAR_MAX : set_year;
		sm  = (set_month < 4'd1) ? 4'd1 : (set_month > 4'd12) ? 4'd12 : set_month;
		dm  = csm_pkg::days_in(sy, sm);
		sd  = (set_day < 5'd1) ? 5'd1 : (set_day > dm) ? dm : set_day;
		sh  = (set_hour > 5'd23) ? 5'd23 : set_hour;
		smi = (set_minute > 6'd59) ? 6'd59 : set_minute;
	end

	// Advance by one minute.
	csm_pkg::time_t nxt;
	always_comb begin
		nxt = now_q;
		if (now_q.minute != 6'd59) nxt.minute = now_q.minute + 6'd1;
		else begin
			nxt.minute = '0;
			if (now_q.hour != 5'd23) nxt.hour = now_q.hour + 5'd1;
			else begin
				nxt.hour    = '0;
				nxt.weekday = csm_pkg::add7(now_q.weekday, 3'd1);
				if (now_q.day < csm_pkg::days_in(now_q.year, now_q.month))
					nxt.day = now_q.day + 5'd1;
				else begin
					nxt.day = 5'd1;
					if (now_q.month != 4'd12) nxt.month = now_q.month + 4'd1;
					else begin
						nxt.month = 4'd1;
						if (now_q.year != csm_pkg::YEAR_MAX) nxt.year = now_q.year + 14'd1;
						else begin
							nxt.year    = csm_pkg::YEAR_MIN;
							nxt.weekday = csm_pkg::WD_EPOCH;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q   <= '{year: csm_pkg::YEAR_MIN, month: 4'd1, day: 5'd1, hour: 5'd0,
				minute: 6'd0, weekday: csm_pkg::WD_EPOCH};
			wy_q    <= csm_pkg::YEAR_MIN;
			wacc_q  <= csm_pkg::WD_EPOCH;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= ST_SCAN;
					else if (accept && op == csm_pkg::OP_SET) begin
						now_q.year   <= sy;
						now_q.month  <= sm;
						now_q.day    <= sd;
						now_q.hour   <= sh;
						now_q.minute <= smi;
						wy_q         <= csm_pkg::YEAR_MIN;
						wacc_q       <= csm_pkg::WD_EPOCH;
						state_q      <= ST_WDAY;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						now_q   <= nxt;
						state_q <= ST_IDLE;
					end
				end
				ST_WDAY: begin
					if (wy_q == now_q.year) begin
						now_q.weekday <= csm_pkg::add7(csm_pkg::add7(wacc_q,
							csm_pkg::month_offset(now_q.month, csm_pkg::is_leap(wy_q))),
							csm_pkg::mod7(5'(now_q.day - 5'd1)));
						state_q <= ST_IDLE;
					end else begin
						wacc_q <= csm_pkg::add7(wacc_q,
							csm_pkg::is_leap(wy_q) ? 3'd2 : 3'd1);
						wy_q   <= wy_q + 14'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CSM_ASSERT_IMPL(a_out_in_scan, out_valid, state_q == ST_SCAN)
	`CSM_ASSERT_IMPL(a_tok_onehot, 1'b1, $onehot0(tok))
	`CSM_ASSERT_NEXT(a_tick_scans, start, state_q == ST_SCAN)
endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [13:0] set_year;
	logic [3:0]  set_month;
	logic [4:0]  set_day;
	logic [4:0]  set_hour;
	logic [5:0]  set_minute;
	logic [3:0]  rule_slot;
	logic [2:0]  mask_kind;
	logic [59:0] mask_bits;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  fired_rule;
	logic [13:0] at_year;
	logic [3:0]  at_month;
	logic [4:0]  at_day;
	logic [4:0]  at_hour;
	logic [5:0]  at_minute;
	logic        last;

	// Undefined op code: accepted and dropped by the block.
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam logic [2:0] KIND_BAD = 3'd7;
	localparam logic [59:0] ALL_ONES = '1;

	cron_schedule_matcher u_top (.*);

	// One expected match transfer.
	typedef struct {
		logic [3:0]  rule;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic        lst;
	} match_t;

	match_t match_q[$];
	int     errors;
	// Quiet phase: no idling on either side.
	bit     calm;

	// Shadow calendar and rule table.
	int          cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_wday;
	logic [59:0] rule_min[16];
	logic [23:0] rule_hr[16];
	logic [30:0] rule_day[16];
	logic [11:0] rule_mon[16];
	logic [6:0]  rule_wd[16];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic bit leap_year(int y);
		return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
	endfunction

	function automatic int month_days(int y, int m);
		if (m == 2)
			return leap_year(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	// Day count from 1970-01-01 (a Thursday) folded to a weekday, Sunday = 0.
	function automatic int weekday_from(int y, int m, int d);
		int days;
		days = d - 1;
		for (int yy = 1970; yy < y; yy++)
			days += leap_year(yy) ? 366 : 365;
		for (int mm = 1; mm < m; mm++)
			days += month_days(y, mm);
		return (4 + days) % 7;
	endfunction

	function automatic void step_minute();
		cal_minute++;
		if (cal_minute < 60) return;
		cal_minute = 0;
		cal_hour++;
		if (cal_hour < 24) return;
		cal_hour = 0;
		cal_wday = (cal_wday + 1) % 7;
		cal_day++;
		if (cal_day <= month_days(cal_year, cal_month)) return;
		cal_day = 1;
		cal_month++;
		if (cal_month <= 12) return;
		cal_month = 1;
		cal_year++;
		if (cal_year > 9999) begin
			cal_year = 1970;
			cal_wday = 4;
		end
	endfunction

	// Applies one accepted op to the shadow state, queueing any matches.
	function automatic void apply_op(logic [1:0] o, int y, int m, int d, int h, int mi,
			int slot, logic [2:0] kind, logic [59:0] bits);
		match_t mt;
		int     first;
		case (o)
			csm_pkg::OP_SET: begin
				// each field clamps into range, day against the clamped month
				if (y < 1970) y = 1970;
				if (y > 9999) y = 9999;
				if (m < 1) m = 1;
				if (m > 12) m = 12;
				if (d < 1) d = 1;
				if (d > month_days(y, m)) d = month_days(y, m);
				if (h > 23) h = 23;
				if (mi > 59) mi = 59;
				cal_year = y; cal_month = m; cal_day = d; cal_hour = h; cal_minute = mi;
				cal_wday = weekday_from(y, m, d);
			end
			csm_pkg::OP_MASK: begin
				case (kind)
					csm_pkg::KIND_MINUTE:  rule_min[slot] = bits;
					csm_pkg::KIND_HOUR:    rule_hr[slot]  = bits[23:0];
					csm_pkg::KIND_DAY:     rule_day[slot] = bits[30:0];
					csm_pkg::KIND_MONTH:   rule_mon[slot] = bits[11:0];
					csm_pkg::KIND_WEEKDAY: rule_wd[slot]  = bits[6:0];
					default: ;
				endcase
			end
			csm_pkg::OP_TICK: begin
				first = match_q.size();
				for (int r = 0; r < 16; r++) begin
					if (rule_min[r][cal_minute] && rule_hr[r][cal_hour] &&
							rule_day[r][cal_day-1] && rule_mon[r][cal_month-1] &&
							rule_wd[r][cal_wday]) begin
						mt.rule = 4'(r); mt.year = 14'(cal_year); mt.month = 4'(cal_month);
						mt.day = 5'(cal_day); mt.hour = 5'(cal_hour);
						mt.minute = 6'(cal_minute);
						mt.lst = 1'b0;
						match_q = {match_q, mt};
					end
				end
				if (match_q.size() > first)
					match_q[$].lst = 1'b1;
				step_minute();
			end
			default: ;
		endcase
	endfunction

	// Drives one op and waits for its transfer. Called at a rising edge.
	task automatic send_op(logic [1:0] o, int y = 0, int m = 0, int d = 0, int h = 0,
			int mi = 0, int slot = 0, logic [2:0] kind = csm_pkg::KIND_MINUTE,
			logic [59:0] bits = '0);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= o;
		set_year   <= 14'(y);
		set_month  <= 4'(m);
		set_day    <= 5'(d);
		set_hour   <= 5'(h);
		set_minute <= 6'(mi);
		rule_slot  <= 4'(slot);
		mask_kind  <= kind;
		mask_bits  <= bits;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		apply_op(o, y, m, d, h, mi, slot, kind, bits);
	endtask

	task automatic set_clock(int y, int m, int d, int h, int mi);
		send_op(csm_pkg::OP_SET, y, m, d, h, mi);
	endtask

	task automatic write_mask(int slot, logic [2:0] kind, logic [59:0] bits);
		send_op(csm_pkg::OP_MASK, 0, 0, 0, 0, 0, slot, kind, bits);
	endtask

	task automatic tick();
		send_op(csm_pkg::OP_TICK);
	endtask

	task automatic open_rule(int slot);
		write_mask(slot, csm_pkg::KIND_MINUTE, ALL_ONES);
		write_mask(slot, csm_pkg::KIND_HOUR, ALL_ONES);
		write_mask(slot, csm_pkg::KIND_DAY, ALL_ONES);
		write_mask(slot, csm_pkg::KIND_MONTH, ALL_ONES);
		write_mask(slot, csm_pkg::KIND_WEEKDAY, ALL_ONES);
	endtask

	// Empty table after reset: ticks move the clock but nothing fires.
	task automatic test_empty_table();
		tick();
		tick();
	endtask

	// Fully open rules at both ends of the table, excess mask bits included.
	task automatic test_open_rules();
		open_rule(0);
		tick();
		open_rule(15);
		tick();
	endtask

	// Out-of-range clock fields clamp; the top of the calendar wraps to 1970 Thursday.
	task automatic test_clock_limits();
		set_clock(0, 0, 0, 31, 63);
		tick();
		set_clock(16383, 15, 31, 31, 63);
		tick();
		write_mask(15, csm_pkg::KIND_WEEKDAY, 60'h10);
		tick();
		tick();
	endtask

	// Undefined op and a bad mask kind leave everything alone.
	task automatic test_ignored_ops();
		send_op(OP_NONE, 16383, 15, 31, 31, 63, 15, csm_pkg::KIND_MINUTE, '0);
		write_mask(0, KIND_BAD, '0);
		write_mask(0, 3'd5, '0);
		tick();
	endtask

	// February roll-over in a leap and a non-leap century year.
	task automatic test_leap_days();
		set_clock(2000, 2, 28, 23, 59);
		tick();
		tick();
		set_clock(2100, 2, 29, 23, 59);
		tick();
	endtask

	// Mostly ticks over a fairly dense rule table, with clock sets near
	// boundaries and the odd ignored op.
	task automatic test_random_traffic(int count);
		int          sel;
		logic [59:0] bits;
		for (int i = 0; i < count; i++) begin
			if (i >= count - 60)
				calm = 1'b1;
			sel = $urandom_range(0, 99);
			if (sel < 62) begin
				tick();
			end else if (sel < 92) begin
				case ($urandom_range(0, 9)) inside
					0:       bits = '0;
					[1:3]:   bits = 60'({$urandom, $urandom});
					default: bits = ALL_ONES;
				endcase
				write_mask($urandom_range(0, 15),
					($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
						: 3'($urandom_range(0, 4)), bits);
			end else if (sel < 98) begin
				if ($urandom_range(0, 5) == 0)
					// far years make the weekday derivation slow; keep these rare
					set_clock($urandom_range(0, 16383), $urandom_range(0, 15),
						$urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 63));
				else
					set_clock($urandom_range(1970, 2110), $urandom_range(1, 12),
						$urandom_range(27, 31), $urandom_range(22, 23),
						$urandom_range(55, 59));
			end else begin
				send_op(OP_NONE, $urandom_range(0, 16383), 0, 0, 0, 0, 0,
					csm_pkg::KIND_MINUTE, '0);
			end
		end
	endtask

	// Receiver back-pressure in random bursts.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_left = 0;
			out_stall  <= 1'b0;
		end else begin
			if (stall_left > 0)
				stall_left--;
			else if (!calm && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 6);
			out_stall <= (stall_left > 0);
		end
	end

	// Each output transfer against the oldest queued match.
	always @(posedge clk) begin
		match_t mt;
		if (arst_n && out_valid && !out_stall) begin
			if (match_q.size() == 0) begin
				$error("unexpected match transfer: rule %0d", fired_rule);
				errors++;
			end else begin
				mt = match_q.pop_front();
				if (fired_rule !== mt.rule) begin
					$error("fired_rule exp %0d got %0d", mt.rule, fired_rule); errors++;
				end
				if (at_year !== mt.year) begin
					$error("at_year exp %0d got %0d", mt.year, at_year); errors++;
				end
				if (at_month !== mt.month) begin
					$error("at_month exp %0d got %0d", mt.month, at_month); errors++;
				end
				if (at_day !== mt.day) begin
					$error("at_day exp %0d got %0d", mt.day, at_day); errors++;
				end
				if (at_hour !== mt.hour) begin
					$error("at_hour exp %0d got %0d", mt.hour, at_hour); errors++;
				end
				if (at_minute !== mt.minute) begin
					$error("at_minute exp %0d got %0d", mt.minute, at_minute); errors++;
				end
				if (last !== mt.lst) begin
					$error("last exp %0d got %0d", mt.lst, last); errors++;
				end
			end
		end
	end

	initial begin
		int waited;
		clk        = 1'b0;
		arst_n     = 1'b0;
		errors     = 0;
		calm       = 1'b0;
		in_valid   <= 1'b0;
		op         <= OP_NONE;
		set_year   <= '0;
		set_month  <= '0;
		set_day    <= '0;
		set_hour   <= '0;
		set_minute <= '0;
		rule_slot  <= '0;
		mask_kind  <= csm_pkg::KIND_MINUTE;
		mask_bits  <= '0;
		cal_year = 1970; cal_month = 1; cal_day = 1; cal_hour = 0; cal_minute = 0;
		cal_wday = 4;
		for (int r = 0; r < 16; r++) begin
			rule_min[r] = '0; rule_hr[r] = '0; rule_day[r] = '0;
			rule_mon[r] = '0; rule_wd[r] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_open_rules();
		test_clock_limits();
		test_ignored_ops();
		test_leap_days();
		test_random_traffic(300);

		in_valid <= 1'b0;
		// drain, then give a scan's worth of cycles for any stray transfer
		waited = 0;
		while (match_q.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (errors == 0 && match_q.size() == 0) begin
			$display("PASS cron_schedule_matcher");
		end else begin
			$display("FAIL cron_schedule_matcher");
		end
		$finish;
	end

	// Far above the slowest correct run, including a handful of slow clock sets.
	initial begin
		#10ms;
		$display("FAIL cron_schedule_matcher");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/csm_pkg.sv
src/csm_cell.sv
src/csm_link.sv
src/cron_schedule_matcher.sv
verif/testbench.sv
